@@ rtl/core/ghst_pkg.sv @@
package ghst_pkg;

  localparam int SLOT_COUNT = 64;
  localparam int GEN_BITS   = 16;
  localparam int DATA_BITS  = 64;

  localparam int ADDR_W = $clog2(SLOT_COUNT);
  localparam int CNT_W  = $clog2(SLOT_COUNT + 1);

  localparam int REQ_W  = 3;
  localparam int IDX_W  = 6;
  localparam int HGEN_W = 16;
  localparam int PAY_W  = 64;
  localparam int LIVE_W = 6;

  typedef enum logic [REQ_W-1:0] {
    REQ_CREATE = 3'd0,
    REQ_UPDATE = 3'd1,
    REQ_REMOVE = 3'd2,
    REQ_GET    = 3'd3,
    REQ_COUNT  = 3'd4
  } req_type_e;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } ctrl_state_e;

  typedef struct packed {
    logic [GEN_BITS-1:0]  gen;
    logic [DATA_BITS-1:0] payload;
  } slot_entry_t;

  typedef struct packed {
    logic              occ_set;
    logic              occ_clr;
    logic              gen_mark;
    logic [ADDR_W-1:0] addr;
  } occ_update_t;

  typedef struct packed {
    logic              free_ok;
    logic [ADDR_W-1:0] free_idx;
    logic              occupied;
    logic              gen_valid;
    logic [CNT_W-1:0]  count;
  } occ_status_t;

  // Mask of all slot positions whose index has the given bit set.
  function automatic logic [SLOT_COUNT-1:0] index_bit_mask(input int b);
    logic [SLOT_COUNT-1:0] mask;
    mask = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      mask[i] = ((i >> b) & 1) != 0;
    end
    return mask;
  endfunction

endpackage

@@ rtl/core/ghst_slot_ram.sv @@
module ghst_slot_ram
  import ghst_pkg::*;
(
  input  logic              clk_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output slot_entry_t       rdata_o,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  slot_entry_t       wdata_i
);

  slot_entry_t mem [SLOT_COUNT];
  slot_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/ghst_occ_track.sv @@
module ghst_occ_track
  import ghst_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  occ_update_t       upd_i,
  input  logic [ADDR_W-1:0] query_addr_i,
  output occ_status_t       status_o
);

  logic [SLOT_COUNT-1:0] occ_q, occ_d;
  logic [SLOT_COUNT-1:0] genw_q, genw_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [SLOT_COUNT-1:0] free_vec;
  logic [SLOT_COUNT-1:0] lowest_free;
  logic [ADDR_W-1:0]     free_idx;

  // Slot zero is never handed out, so it is masked from the free set.
  assign free_vec    = ~occ_q & ~SLOT_COUNT'(1);
  assign lowest_free = free_vec & (~free_vec + SLOT_COUNT'(1));

  always_comb begin
    for (int b = 0; b < ADDR_W; b++) begin
      free_idx[b] = |(lowest_free & index_bit_mask(b));
    end
  end

  always_comb begin
    occ_d   = occ_q;
    genw_d  = genw_q;
    count_d = count_q;
    if (upd_i.occ_set) begin
      occ_d[upd_i.addr] = 1'b1;
      count_d           = count_q + CNT_W'(1);
    end else if (upd_i.occ_clr) begin
      occ_d[upd_i.addr] = 1'b0;
      count_d           = count_q - CNT_W'(1);
    end
    if (upd_i.gen_mark) begin
      genw_d[upd_i.addr] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q   <= '0;
      genw_q  <= '0;
      count_q <= '0;
    end else begin
      occ_q   <= occ_d;
      genw_q  <= genw_d;
      count_q <= count_d;
    end
  end

  assign status_o.free_ok   = |free_vec;
  assign status_o.free_idx  = free_idx;
  assign status_o.occupied  = occ_q[query_addr_i];
  assign status_o.gen_valid = genw_q[query_addr_i];
  assign status_o.count     = count_q;

endmodule

@@ rtl/core/generational_handle_slot_table.sv @@
// Slot table addressed by handles of an index and a generation. The idle state accepts a
// request and reads the addressed slot from the slot memory (generation and payload share
// one entry); the exec state checks the handle, writes the slot back and loads the result
// register. A new request is taken only once the last has left the exec state. A stalled
// result holds back only the exec step of the following request. Occupancy, the live count
// and a per-slot written flag for the generation live in flip-flops that reset clears at once,
// so the block is ready right after reset with no clearing pass. Create takes the lowest free
// slot from index 1 up; a full table answers create with ok low.
module generational_handle_slot_table
  import ghst_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [87:0] s_axis_tdata,  // slot_index, handle_gen, payload_in
  input  logic [2:0]  s_axis_tuser,  // req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata,  // out_index, out_gen, payload_out, live_count
  output logic [0:0]  m_axis_tuser   // ok
);

  ctrl_state_e state_q, state_d;

  req_type_e         req_type_q;
  logic [IDX_W-1:0]  idx_q;
  logic [HGEN_W-1:0] hgen_q;
  logic [PAY_W-1:0]  pay_q;
  logic [ADDR_W-1:0] addr_q;
  logic              free_ok_q;

  logic              m_valid_q;
  logic              ok_q;
  logic [IDX_W-1:0]  oidx_q;
  logic [HGEN_W-1:0] ogen_q;
  logic [PAY_W-1:0]  opay_q;
  logic [LIVE_W-1:0] live_q;

  logic              s_fire;
  logic              exec_go;
  req_type_e         s_req_type;
  logic [ADDR_W-1:0] rd_addr;

  slot_entry_t       rdata;
  slot_entry_t       wdata;
  logic              we;
  occ_update_t       upd;
  occ_status_t       status;

  logic [GEN_BITS-1:0] gen_cur;
  logic [GEN_BITS-1:0] gen_inc;
  logic [GEN_BITS-1:0] gen_next;
  logic                in_range;
  logic                handle_ok;

  logic              ok_c;
  logic [IDX_W-1:0]  oidx_c;
  logic [HGEN_W-1:0] ogen_c;
  logic [PAY_W-1:0]  opay_c;
  logic [CNT_W-1:0]  count_c;

  assign s_fire     = s_axis_tvalid && s_axis_tready;
  assign s_req_type = req_type_e'(s_axis_tuser);
  assign rd_addr    = (s_req_type == REQ_CREATE) ? status.free_idx
                                                 : ADDR_W'(s_axis_tdata[5:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    exec_go       = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!m_valid_q || m_axis_tready) begin
          exec_go = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      req_type_q <= s_req_type;
      idx_q      <= s_axis_tdata[5:0];
      hgen_q     <= s_axis_tdata[21:6];
      pay_q      <= s_axis_tdata[85:22];
      addr_q     <= rd_addr;
      free_ok_q  <= status.free_ok;
    end
  end

  ghst_slot_ram u_ram (
    .clk_i   (clk_i),
    .re_i    (s_fire),
    .raddr_i (rd_addr),
    .rdata_o (rdata),
    .we_i    (we),
    .waddr_i (addr_q),
    .wdata_i (wdata)
  );

  ghst_occ_track u_occ (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .upd_i        (upd),
    .query_addr_i (addr_q),
    .status_o     (status)
  );

  // A generation that was never written is read as one, since the slot memory is not reset.
  assign gen_cur   = status.gen_valid ? rdata.gen : GEN_BITS'(1);
  assign gen_inc   = gen_cur + GEN_BITS'(1);
  assign gen_next  = (gen_inc == '0) ? GEN_BITS'(1) : gen_inc;
  assign in_range  = int'(idx_q) < SLOT_COUNT;
  assign handle_ok = in_range && status.occupied && (gen_cur == GEN_BITS'(hgen_q));

  always_comb begin
    ok_c          = 1'b0;
    oidx_c        = idx_q;
    ogen_c        = '0;
    opay_c        = '0;
    count_c       = status.count;
    we            = 1'b0;
    wdata.gen     = gen_cur;
    wdata.payload = rdata.payload;
    upd.occ_set   = 1'b0;
    upd.occ_clr   = 1'b0;
    upd.gen_mark  = 1'b0;
    upd.addr      = addr_q;
    case (req_type_q)
      REQ_CREATE: begin
        oidx_c = '0;
        if (free_ok_q) begin
          ok_c          = 1'b1;
          oidx_c        = IDX_W'(addr_q);
          ogen_c        = HGEN_W'(gen_cur);
          count_c       = status.count + CNT_W'(1);
          wdata.payload = DATA_BITS'(pay_q);
          we            = exec_go;
          upd.occ_set   = exec_go;
          upd.gen_mark  = exec_go;
        end
      end
      REQ_UPDATE: begin
        if (handle_ok) begin
          ok_c          = 1'b1;
          wdata.payload = DATA_BITS'(pay_q);
          we            = exec_go;
          upd.gen_mark  = exec_go;
        end
      end
      REQ_REMOVE: begin
        if (handle_ok) begin
          ok_c          = 1'b1;
          count_c       = status.count - CNT_W'(1);
          wdata.gen     = gen_next;
          wdata.payload = '0;
          we            = exec_go;
          upd.occ_clr   = exec_go;
          upd.gen_mark  = exec_go;
        end
      end
      REQ_GET: begin
        if (handle_ok) begin
          ok_c   = 1'b1;
          opay_c = PAY_W'(rdata.payload);
        end
      end
      REQ_COUNT: begin
        ok_c = 1'b1;
      end
      default: begin
        ok_c = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (exec_go) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_go) begin
      ok_q   <= ok_c;
      oidx_q <= oidx_c;
      ogen_q <= ogen_c;
      opay_q <= opay_c;
      live_q <= LIVE_W'(count_c);
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = ok_q;
  assign m_axis_tdata  = {4'b0, live_q, opay_q, ogen_q, oidx_q};

`ifndef SYNTHESIS
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |=> !s_axis_tready)
    else $error("request accepted while another is in flight");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_go |=> m_axis_tvalid)
    else $error("finished request produced no result");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(status.count) <= SLOT_COUNT - 1)
    else $error("occupied count exceeds usable slots");

  a_create_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_go && (req_type_q == REQ_CREATE) && free_ok_q |-> addr_q != '0)
    else $error("slot zero allocated");
`endif

endmodule
